// ----- rtl/hkrs_pkg.sv -----
`timescale 1ns / 1ps

package hkrs_pkg;

   // Physical report width is fixed at six keycode slots.
   localparam int unsigned TABLE_MAX          = 6;
   localparam int unsigned SLOT_COUNT_DEFAULT = 6;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned HOLD_W = 4;

   localparam logic [HOLD_W-1:0] STANDARD_HOLD_RESET = 4'd3;
   localparam logic [HOLD_W-1:0] MODIFIER_HOLD_RESET = 4'd2;

   // Item modes
   localparam logic [1:0] MODE_PRESS   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_REPORT  = 2'd2;

   // Register indexes
   localparam logic CSR_STANDARD_HOLD = 1'b0;
   localparam logic CSR_MODIFIER_HOLD = 1'b1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [CODE_W-1:0] keycode;
      logic [CODE_W-1:0] modifier_bits;
      logic              auto_release;
      logic              is_system_modifier;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] slot0_code;
      logic [CODE_W-1:0] slot1_code;
      logic [CODE_W-1:0] slot2_code;
      logic [CODE_W-1:0] slot3_code;
      logic [CODE_W-1:0] slot4_code;
      logic [CODE_W-1:0] slot5_code;
      logic [CODE_W-1:0] report_modifier;
   } rsp_type;

   typedef struct packed {
      logic [HOLD_W-1:0] standard_hold;
      logic [HOLD_W-1:0] modifier_hold;
   } hold_cfg_type;

endpackage

// ----- rtl/hkrs_slot_table.sv -----
`timescale 1ns / 1ps

module hkrs_slot_table
   import hkrs_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         exec_valid,
   input  req_type      exec_item,
   input  hold_cfg_type hold_cfg,
   output rsp_type      report
);

   logic [SLOT_COUNT-1:0][CODE_W-1:0] codes_ff, codes_in;
   logic [SLOT_COUNT-1:0][HOLD_W-1:0] cd_ff, cd_in;
   logic [CODE_W-1:0]                 mod_ff, mod_in;

   logic [SLOT_COUNT-1:0] ins_sel;
   logic                  present;
   logic                  free_seen;
   logic [HOLD_W-1:0]     load_cd;
   logic [TABLE_MAX-1:0][CODE_W-1:0] padded;

   // Presence test and lowest-empty-slot pick, all slots in parallel.
   always_comb begin
      present   = 1'b0;
      free_seen = 1'b0;
      ins_sel   = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (codes_ff[s] == exec_item.keycode) begin
            present = 1'b1;
         end
         if (codes_ff[s] == '0 && !free_seen) begin
            ins_sel[s] = 1'b1;
            free_seen  = 1'b1;
         end
      end
   end

   assign load_cd = !exec_item.auto_release     ? '0 :
                    exec_item.is_system_modifier ? hold_cfg.modifier_hold :
                                                   hold_cfg.standard_hold;

   always_comb begin
      codes_in = codes_ff;
      cd_in    = cd_ff;
      mod_in   = mod_ff;
      case (exec_item.mode)
         MODE_PRESS: begin
            if (!present && free_seen) begin
               for (int s = 0; s < SLOT_COUNT; s++) begin
                  if (ins_sel[s]) begin
                     codes_in[s] = exec_item.keycode;
                     cd_in[s]    = load_cd;
                  end
               end
               mod_in = exec_item.modifier_bits;
            end
         end
         MODE_RELEASE: begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (codes_ff[s] == exec_item.keycode) begin
                  codes_in[s] = '0;
                  cd_in[s]    = '0;
                  mod_in      = '0;
               end
            end
         end
         MODE_REPORT: begin
            // 1 or 2 expire now; above 2 ages by one; 0 never expires
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (cd_ff[s] == HOLD_W'(1) || cd_ff[s] == HOLD_W'(2)) begin
                  codes_in[s] = '0;
                  cd_in[s]    = '0;
                  mod_in      = '0;
               end else if (cd_ff[s] > HOLD_W'(2)) begin
                  cd_in[s] = cd_ff[s] - HOLD_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '0;
         cd_ff    <= '0;
         mod_ff   <= '0;
      end else if (exec_valid) begin
         codes_ff <= codes_in;
         cd_ff    <= cd_in;
         mod_ff   <= mod_in;
      end
   end

   // Slots that do not exist read as zero.
   for (genvar g = 0; g < TABLE_MAX; g++) begin : g_pad
      if (g < SLOT_COUNT) begin : g_live
         assign padded[g] = codes_ff[g];
      end else begin : g_dead
         assign padded[g] = '0;
      end
   end

   assign report.slot0_code      = padded[0];
   assign report.slot1_code      = padded[1];
   assign report.slot2_code      = padded[2];
   assign report.slot3_code      = padded[3];
   assign report.slot4_code      = padded[4];
   assign report.slot5_code      = padded[5];
   assign report.report_modifier = mod_ff;

endmodule

// ----- rtl/hid_key_report_slot_table.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Ports                          | Beat
// req     | in        | req_valid, req_stall, req_data | press / release / report item
// rsp     | out       | rsp_valid, rsp_stall, rsp_data | report: six slots + modifier
// csr     | in        | csr_write_enable, csr_index,   | hold-count register write
//         |           | csr_write_data                 |
//
// One item per cycle unless a report is held: an accepted beat lands in
// the input stage; the slot table update (compare + priority pick over
// all slots) runs as it leaves, with a report registered out at that edge.
// Reset clears the slot table, modifier and stage/result valids; the hold
// counts return to 3 (standard) and 2 (system modifier).
// A report waiting in the stage holds (and stalls req) only while the result
// register is full and rsp_stall is high; press and release beats never wait.

module hid_key_report_slot_table
   import hkrs_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [HOLD_W-1:0] csr_write_data
);

   hold_cfg_type hold_ff;

   logic    stage_valid_ff;
   req_type stage_ff;
   logic    stage_is_report;
   logic    stage_advance;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type report;

   // hold-count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.standard_hold <= STANDARD_HOLD_RESET;
         hold_ff.modifier_hold <= MODIFIER_HOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STANDARD_HOLD: hold_ff.standard_hold <= csr_write_data;
            CSR_MODIFIER_HOLD: hold_ff.modifier_hold <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // A report needs room in the result register; other modes always go.
   assign stage_is_report = stage_ff.mode == MODE_REPORT;
   assign stage_advance   = stage_valid_ff &&
                            (!stage_is_report || !rsp_valid_ff || !rsp_stall);
   assign req_stall       = stage_valid_ff && !stage_advance;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_ff <= req_data;
      end
   end

   hkrs_slot_table #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .exec_valid (stage_advance),
      .exec_item  (stage_ff),
      .hold_cfg   (hold_ff),
      .report     (report)
   );

   // result register: the table as it stands before the report ages it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_advance && stage_is_report) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_advance && stage_is_report) begin
         rsp_data_ff <= report;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // A result only appears after a report beat left the stage.
   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_advance && stage_is_report))
      else $error("result raised without a report");

   // A report blocked by a stalled result stays put.
   a_report_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_is_report && rsp_valid_ff && rsp_stall)
      |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("blocked report lost");

   // Press and release beats never back-pressure the input.
   a_no_stall_nonreport: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_is_report) |-> !req_stall)
      else $error("non-report beat stalled");
`endif

endmodule
